### rtl/stt_pkg.sv
// ============================================================================
// stt_pkg
// shared types, codes and character constants of the scene text tokenizer
// ============================================================================
package stt_pkg;

   localparam int COLUMN_BITS_DEFAULT = 16;
   localparam int LINE_BITS_DEFAULT   = 20;
   localparam int KIND_W              = 3;
   localparam int QUEUE_DEPTH         = 4;

   // scanner modes
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_QUOTE   = 3'd2,
      MODE_NUM     = 3'd3,
      MODE_COMMENT = 3'd4,
      MODE_SIGN    = 3'd5
   } mode_type;

   // number phases
   typedef enum logic [2:0] {
      PH_INT   = 3'd0,
      PH_FRAC  = 3'd1,
      PH_EXP   = 3'd2,
      PH_ESIGN = 3'd3,
      PH_EDIG  = 3'd4
   } phase_type;

   // token kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_WORD  = 3'd0,
      KIND_QUOTE = 3'd1,
      KIND_NUM   = 3'd2,
      KIND_LB    = 3'd3,
      KIND_RB    = 3'd4,
      KIND_END   = 3'd5
   } kind_type;

   // character codes
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_HASH   = 8'd35;
   localparam logic [7:0] CH_QUOTE  = 8'd34;
   localparam logic [7:0] CH_PLUS   = 8'd43;
   localparam logic [7:0] CH_MINUS  = 8'd45;
   localparam logic [7:0] CH_DOT    = 8'd46;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_UP_A   = 8'd65;
   localparam logic [7:0] CH_UP_Z   = 8'd90;
   localparam logic [7:0] CH_LO_A   = 8'd97;
   localparam logic [7:0] CH_LO_Z   = 8'd122;
   localparam logic [7:0] CH_UP_E   = 8'd69;
   localparam logic [7:0] CH_LO_E   = 8'd101;
   localparam logic [7:0] CH_LBRACK = 8'd91;
   localparam logic [7:0] CH_RBRACK = 8'd93;

   // token queue status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

endpackage

### rtl/stt_scanner.sv
// ============================================================================
// stt_scanner
// front end: classifies one byte per cycle while accept is high and forms up to two token records
// ============================================================================
module stt_scanner #(
   parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEFAULT,
   parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEFAULT,
   parameter int TOK_W       = stt_pkg::KIND_W + LINE_BITS + 2 * COLUMN_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         char_code,
   input  logic               end_of_input,
   output logic               push,
   output logic [2*TOK_W:0]   push_entry   // first token, second token, second valid
);

   stt_pkg::mode_type        mode_ff, mode_in;
   stt_pkg::phase_type       phase_ff, phase_in;
   logic [COLUMN_BITS-1:0]   start_ff, start_in;
   logic [COLUMN_BITS-1:0]   col_ff, col_in;
   logic [COLUMN_BITS-1:0]   mark_ff, mark_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;

   logic [COLUMN_BITS-1:0]   col_sat;
   logic [LINE_BITS-1:0]     line_sat;

   logic is_space, is_digit, is_alpha, is_e, is_sign, is_dot;

   // idle scan of the current byte
   stt_pkg::mode_type        ib_mode;
   logic                     ib_set_start;
   logic [COLUMN_BITS-1:0]   ib_start;
   logic                     ib_set_phase;
   stt_pkg::phase_type       ib_phase;
   logic                     ib_emit;
   stt_pkg::kind_type        ib_kind;

   logic                     r0_v, r1_v;
   logic [TOK_W-1:0]         r0_tok, r1_tok;

   function automatic logic [TOK_W-1:0] mk_tok(
      input stt_pkg::kind_type      kind,
      input logic [LINE_BITS-1:0]   line,
      input logic [COLUMN_BITS-1:0] s,
      input logic [COLUMN_BITS-1:0] e
   );
      mk_tok = {e, s, line, kind};
   endfunction

   assign col_sat  = (col_ff == {COLUMN_BITS{1'b1}}) ? col_ff : col_ff + 1'b1;
   assign line_sat = (line_ff == {LINE_BITS{1'b1}}) ? line_ff : line_ff + 1'b1;

   assign is_space = (char_code == stt_pkg::CH_SPACE) ||
                     ((char_code >= stt_pkg::CH_TAB) && (char_code <= stt_pkg::CH_CR));
   assign is_digit = (char_code >= stt_pkg::CH_ZERO) && (char_code <= stt_pkg::CH_NINE);
   assign is_alpha = ((char_code >= stt_pkg::CH_UP_A) && (char_code <= stt_pkg::CH_UP_Z)) ||
                     ((char_code >= stt_pkg::CH_LO_A) && (char_code <= stt_pkg::CH_LO_Z));
   assign is_e     = (char_code == stt_pkg::CH_UP_E) || (char_code == stt_pkg::CH_LO_E);
   assign is_sign  = (char_code == stt_pkg::CH_PLUS) || (char_code == stt_pkg::CH_MINUS);
   assign is_dot   = (char_code == stt_pkg::CH_DOT);

   always_comb begin
      ib_mode      = stt_pkg::MODE_IDLE;
      ib_set_start = 1'b0;
      ib_start     = col_ff;
      ib_set_phase = 1'b0;
      ib_phase     = stt_pkg::PH_INT;
      ib_emit      = 1'b0;
      ib_kind      = stt_pkg::KIND_LB;
      if (is_space) begin
         ib_mode = stt_pkg::MODE_IDLE;
      end else if (char_code == stt_pkg::CH_HASH) begin
         ib_mode = stt_pkg::MODE_COMMENT;
      end else if (is_sign || is_dot) begin
         ib_mode      = stt_pkg::MODE_SIGN;
         ib_set_start = 1'b1;
         ib_set_phase = 1'b1;
         ib_phase     = is_dot ? stt_pkg::PH_FRAC : stt_pkg::PH_INT;
      end else if (is_digit) begin
         ib_mode      = stt_pkg::MODE_NUM;
         ib_set_start = 1'b1;
         ib_set_phase = 1'b1;
      end else if (is_alpha) begin
         ib_mode      = stt_pkg::MODE_WORD;
         ib_set_start = 1'b1;
      end else if (char_code == stt_pkg::CH_LBRACK) begin
         ib_emit = 1'b1;
      end else if (char_code == stt_pkg::CH_RBRACK) begin
         ib_emit = 1'b1;
         ib_kind = stt_pkg::KIND_RB;
      end else if (char_code == stt_pkg::CH_QUOTE) begin
         ib_mode      = stt_pkg::MODE_QUOTE;
         ib_set_start = 1'b1;
         ib_start     = col_sat;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      col_in   = col_ff;
      mark_in  = mark_ff;
      line_in  = line_ff;
      r0_v     = 1'b0;
      r1_v     = 1'b0;
      r0_tok   = mk_tok(stt_pkg::KIND_END, '0, '0, '0);
      r1_tok   = mk_tok(stt_pkg::KIND_END, '0, '0, '0);

      if (end_of_input) begin
         // flush open token, then end token, then back to reset values
         r0_v = 1'b1;
         case (mode_ff)
            stt_pkg::MODE_WORD: begin
               r0_tok = mk_tok(stt_pkg::KIND_WORD, line_ff, start_ff, col_ff);
               r1_v   = 1'b1;
            end
            stt_pkg::MODE_QUOTE: begin
               r0_tok = mk_tok(stt_pkg::KIND_QUOTE, line_ff, start_ff, col_ff);
               r1_v   = 1'b1;
            end
            stt_pkg::MODE_NUM: begin
               r0_tok = mk_tok(stt_pkg::KIND_NUM, line_ff, start_ff, col_ff);
               r1_v   = 1'b1;
            end
            default: begin
               r0_tok = mk_tok(stt_pkg::KIND_END, '0, '0, '0);
            end
         endcase
         mode_in  = stt_pkg::MODE_IDLE;
         phase_in = stt_pkg::PH_INT;
         start_in = '0;
         col_in   = '0;
         mark_in  = '0;
         line_in  = LINE_BITS'(1);
      end else if (char_code == stt_pkg::CH_LF) begin
         case (mode_ff)
            stt_pkg::MODE_WORD: begin
               r0_v   = 1'b1;
               r0_tok = mk_tok(stt_pkg::KIND_WORD, line_ff, start_ff, col_ff);
            end
            stt_pkg::MODE_QUOTE: begin
               r0_v   = 1'b1;
               r0_tok = mk_tok(stt_pkg::KIND_QUOTE, line_ff, start_ff, col_ff);
            end
            stt_pkg::MODE_NUM: begin
               r0_v = 1'b1;
               if ((phase_ff == stt_pkg::PH_EXP) || (phase_ff == stt_pkg::PH_ESIGN)) begin
                  // dangling exponent: number up to the e, word from the e
                  r0_tok = mk_tok(stt_pkg::KIND_NUM, line_ff, start_ff, mark_ff);
                  r1_v   = 1'b1;
                  r1_tok = mk_tok(stt_pkg::KIND_WORD, line_ff, mark_ff, col_ff);
               end else begin
                  r0_tok = mk_tok(stt_pkg::KIND_NUM, line_ff, start_ff, col_ff);
               end
            end
            default: begin
            end
         endcase
         mode_in  = stt_pkg::MODE_IDLE;
         phase_in = stt_pkg::PH_INT;
         col_in   = '0;
         line_in  = line_sat;
      end else begin
         col_in = col_sat;
         case (mode_ff)
            stt_pkg::MODE_WORD: begin
               if (is_space) begin
                  r0_v    = 1'b1;
                  r0_tok  = mk_tok(stt_pkg::KIND_WORD, line_ff, start_ff, col_ff);
                  mode_in = stt_pkg::MODE_IDLE;
               end
            end
            stt_pkg::MODE_QUOTE: begin
               if (char_code == stt_pkg::CH_QUOTE) begin
                  r0_v    = 1'b1;
                  r0_tok  = mk_tok(stt_pkg::KIND_QUOTE, line_ff, start_ff, col_ff);
                  mode_in = stt_pkg::MODE_IDLE;
               end
            end
            stt_pkg::MODE_NUM: begin
               if ((phase_ff == stt_pkg::PH_EXP) || (phase_ff == stt_pkg::PH_ESIGN)) begin
                  if (is_digit) begin
                     phase_in = stt_pkg::PH_EDIG;
                  end else if ((phase_ff == stt_pkg::PH_EXP) && is_sign) begin
                     phase_in = stt_pkg::PH_ESIGN;
                  end else begin
                     r0_v     = 1'b1;
                     r0_tok   = mk_tok(stt_pkg::KIND_NUM, line_ff, start_ff, mark_ff);
                     start_in = mark_ff;
                     mode_in  = stt_pkg::MODE_WORD;
                     if (is_space) begin
                        r1_v    = 1'b1;
                        r1_tok  = mk_tok(stt_pkg::KIND_WORD, line_ff, mark_ff, col_ff);
                        mode_in = stt_pkg::MODE_IDLE;
                     end
                  end
               end else if (is_digit) begin
                  mode_in = stt_pkg::MODE_NUM;
               end else if ((phase_ff == stt_pkg::PH_INT) && is_dot) begin
                  phase_in = stt_pkg::PH_FRAC;
               end else if (((phase_ff == stt_pkg::PH_INT) ||
                             (phase_ff == stt_pkg::PH_FRAC)) && is_e) begin
                  phase_in = stt_pkg::PH_EXP;
                  mark_in  = col_ff;
               end else begin
                  // number ends, byte is rescanned as from idle
                  r0_v    = 1'b1;
                  r0_tok  = mk_tok(stt_pkg::KIND_NUM, line_ff, start_ff, col_ff);
                  mode_in = ib_mode;
                  if (ib_set_start) begin
                     start_in = ib_start;
                  end
                  if (ib_set_phase) begin
                     phase_in = ib_phase;
                  end
                  r1_v   = ib_emit;
                  r1_tok = mk_tok(ib_kind, line_ff, col_ff, col_sat);
               end
            end
            stt_pkg::MODE_COMMENT: begin
            end
            stt_pkg::MODE_SIGN: begin
               mode_in = is_digit ? stt_pkg::MODE_NUM : stt_pkg::MODE_IDLE;
            end
            default: begin
               mode_in = ib_mode;
               if (ib_set_start) begin
                  start_in = ib_start;
               end
               if (ib_set_phase) begin
                  phase_in = ib_phase;
               end
               r0_v   = ib_emit;
               r0_tok = mk_tok(ib_kind, line_ff, col_ff, col_sat);
            end
         endcase
      end
   end

   assign push       = accept && r0_v;
   assign push_entry = {r1_v, r1_tok, r0_tok};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stt_pkg::MODE_IDLE;
         phase_ff <= stt_pkg::PH_INT;
         start_ff <= '0;
         col_ff   <= '0;
         mark_ff  <= '0;
         line_ff  <= LINE_BITS'(1);
      end else if (accept) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         start_ff <= start_in;
         col_ff   <= col_in;
         mark_ff  <= mark_in;
         line_ff  <= line_in;
      end
   end

endmodule

### rtl/stt_queue.sv
// ============================================================================
// stt_queue
// short first-in first-out queue of token records between front and back
// ============================================================================
module stt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output stt_pkg::queue_flags_type flags
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign flags.full  = (count_ff == CNT_W'(DEPTH));
   assign flags.empty = (count_ff == '0);
   assign pop_data    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/stt_emitter.sv
// ============================================================================
// stt_emitter
// back end: splits queued records into single tokens on the result channel
// ============================================================================
module stt_emitter #(
   parameter int TOK_W = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stt_pkg::queue_flags_type flags,
   input  logic [2*TOK_W:0]         entry,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [TOK_W-1:0]         out_tok,
   output logic                     out_last
);

   logic             valid_ff, valid_in;
   logic [TOK_W-1:0] tok_ff, tok_in;
   logic             last_ff, last_in;
   logic             pend_ff, pend_in;
   logic [TOK_W-1:0] second_ff, second_in;
   logic             out_free;

   assign out_free = !valid_ff || out_ready;
   assign pop      = out_free && !pend_ff && !flags.empty;

   always_comb begin
      valid_in  = valid_ff;
      tok_in    = tok_ff;
      last_in   = last_ff;
      pend_in   = pend_ff;
      second_in = second_ff;
      if (out_free) begin
         if (pend_ff) begin
            // second token of the held record
            valid_in = 1'b1;
            tok_in   = second_ff;
            last_in  = 1'b1;
            pend_in  = 1'b0;
         end else if (!flags.empty) begin
            valid_in  = 1'b1;
            tok_in    = entry[TOK_W-1:0];
            second_in = entry[2*TOK_W-1:TOK_W];
            pend_in   = entry[2*TOK_W];
            last_in   = !entry[2*TOK_W];
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff    <= tok_in;
      last_ff   <= last_in;
      second_ff <= second_in;
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;
   assign out_last  = last_ff;

endmodule

### rtl/scene_text_tokenizer_top.sv
// ============================================================================
// scene_text_tokenizer_top
// streaming tokenizer for scene description text
// ============================================================================
// usage:
//   req_* takes one text byte per transfer: the byte in req_tdata, and
//   req_tuser high to mark end of text (the byte is then ignored).
//   rsp_* gives one token per transfer: kind, line, start and end column
//   in rsp_tdata; rsp_tlast marks the final token caused by one byte.
//   one byte causes zero, one or two tokens; end of text always gives an
//   end token and returns the scanner to its reset state.
// timing:
//   a byte is taken every cycle while the token queue has room; a token
//   reaches rsp through the scanner, then the queue, then the output
//   register. the result side moves one token a cycle while rsp_tready
//   is high, so a byte that causes two tokens takes two transfers.
// reset and stall:
//   reset clears the scanner to line 1, column 0, and empties the queue.
//   when rsp_tready is low the output register holds, the four-entry queue
//   fills, and req_tready drops once it is full.
// ============================================================================
module scene_text_tokenizer_top #(
   parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEFAULT,
   parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // byte channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_code
   input  logic       req_tuser,   // end_of_input
   // token channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // token_kind, token_line, start_column, end_column, zero fill
   output logic [((stt_pkg::KIND_W + LINE_BITS + 2 * COLUMN_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic       rsp_tlast    // last_of_run
);

   localparam int TOK_W   = stt_pkg::KIND_W + LINE_BITS + 2 * COLUMN_BITS;
   localparam int PAD_W   = ((TOK_W + 7) / 8) * 8;
   localparam int ENTRY_W = 2 * TOK_W + 1;

   logic                     accept;
   logic                     push;
   logic [ENTRY_W-1:0]       push_entry;
   logic                     pop;
   logic [ENTRY_W-1:0]       pop_entry;
   stt_pkg::queue_flags_type flags;
   logic [TOK_W-1:0]         out_tok;

   // a new byte is taken whenever the queue can hold its tokens
   assign req_tready = !flags.full;
   assign accept     = req_tvalid && req_tready;

   // front: scanner state machine
   stt_scanner #(
      .COLUMN_BITS (COLUMN_BITS),
      .LINE_BITS   (LINE_BITS),
      .TOK_W       (TOK_W)
   ) u_scanner (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_code    (req_tdata),
      .end_of_input (req_tuser),
      .push         (push),
      .push_entry   (push_entry)
   );

   // decoupling queue of token records
   stt_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (stt_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .flags     (flags)
   );

   // back: one token per transfer
   stt_emitter #(
      .TOK_W (TOK_W)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .flags     (flags),
      .entry     (pop_entry),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (out_tok),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = PAD_W'(out_tok);

   // end token always closes its run
   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_tok[stt_pkg::KIND_W-1:0] == stt_pkg::KIND_END)) |-> rsp_tlast)
      else $error("end token without last marker");

   // end token carries line 0, other tokens a real line
   a_end_line_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_tok[stt_pkg::KIND_W-1:0] == stt_pkg::KIND_END)) |->
      (out_tok[TOK_W-1:stt_pkg::KIND_W] == '0))
      else $error("end token with nonzero line or columns");

   a_token_line_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_tok[stt_pkg::KIND_W-1:0] != stt_pkg::KIND_END)) |->
      (out_tok[stt_pkg::KIND_W+LINE_BITS-1:stt_pkg::KIND_W] != '0))
      else $error("token with line 0");

   // scanner never writes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !flags.full)
      else $error("token queue overflow");

endmodule
